>>> hw/rtl/t2tag_pkg.sv
// Package for the Type 2 tag responder: sizes, command codes, phase and sequencer types.
// No dependencies.
package t2tag_pkg;
    localparam int MEM_BYTES   = 1024;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int FRAME_BYTES = 8;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int FCNT_W      = $clog2(FRAME_BYTES + 1);
    localparam int READ_BYTES  = 16;
    localparam int TX_BYTES    = READ_BYTES + 2;
    localparam int TX_AW       = $clog2(TX_BYTES);

    localparam logic [15:0] CRC_INIT = 16'h6363;
    localparam logic [7:0] CMD_REQA  = 8'h26;
    localparam logic [7:0] CMD_WUPA  = 8'h52;
    localparam logic [7:0] CMD_SEL1  = 8'h93;
    localparam logic [7:0] CMD_SEL2  = 8'h95;
    localparam logic [7:0] NVB_ANTI  = 8'h20;
    localparam logic [7:0] NVB_SEL   = 8'h70;
    localparam logic [7:0] ATQA_LO   = 8'h44;
    localparam logic [7:0] CT_BYTE   = 8'h88;
    localparam logic [7:0] CMD_READ  = 8'h30;
    localparam logic [7:0] CMD_WRITE = 8'hA2;
    localparam logic [7:0] CMD_HALT  = 8'h50;
    localparam logic [7:0] HALT_B2   = 8'h57;
    localparam logic [7:0] RSP_ACK   = 8'h0A;
    localparam logic [7:0] RSP_NAK   = 8'h01;
    localparam logic [7:0] SAK_CASC  = 8'h04;

    localparam logic [1:0] REG_MEM_SIZE = 2'd0;
    localparam logic [1:0] REG_UID1     = 2'd1;
    localparam logic [1:0] REG_UID2     = 2'd2;

    typedef enum logic [1:0] {PH_IDLE, PH_READY, PH_ACTIVE} t_phase;
    typedef enum logic [3:0] {
        S_CLEAR, S_RX, S_DECODE, S_RDADDR, S_RDDATA, S_CRC, S_WRCHK, S_WRMEM,
        S_SEND
    } t_state;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = b ^ crc[7:0];
        c = c ^ {c[3:0], 4'h0};
        return {8'h00, crc[15:8]} ^ {c, 8'h00} ^ {5'h00, c, 3'h0} ^ {12'h000, c[7:4]};
    endfunction
endpackage

>>> hw/rtl/iso14443a_type2_tag_responder.sv
// Type 2 tag frame responder: frame capture, command decode, shared CRC/memory sequencer.
// After frame end, the reply follows decode (ATQA, anticollision), a CRC pass (SELECT),
// a CRC check (WRITE NAK) plus memory write (WRITE ACK), or memory reads and CRC (READ).
// Throughput: one word per cycle in reply unless stalled; not ready in decode and reply.
// A READ walks 16 memory reads then one CRC byte per cycle; WRITE checks CRC over 6 bytes.
// Reset (i_rst_n low, synchronous): phase idle, frame cleared, then a memory clearing
// pass over all 1024 bytes during which no input word is accepted. Depends on t2tag_pkg.
module iso14443a_type2_tag_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // frame_last
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // tx_byte
    output logic        m_axis_tlast    // tx_last
);
    import t2tag_pkg::*;

    logic [10:0] r_mem_size;
    logic [23:0] r_uid1;
    logic [31:0] r_uid2;
    t_phase r_phase, n_phase;
    logic r_halted, n_halted;
    t_state r_state, n_state;
    logic [7:0] r_frame [FRAME_BYTES];
    logic [FCNT_W-1:0] r_fcnt;
    logic [7:0] r_tx [TX_BYTES];
    logic [TX_AW-1:0] r_txn, r_txi, r_cnt;
    logic [15:0] r_crc;
    logic [MEM_AW:0] r_clr;
    logic [7:0] mem [MEM_BYTES];
    logic [7:0] r_rdata;
    logic r_rd_ok;

    logic [11:0] lim;
    logic [11:0] base;
    logic [11:0] paddr;
    assign lim  = (r_mem_size < 11'(MEM_BYTES)) ? {1'b0, r_mem_size} : 12'(MEM_BYTES);
    assign base = {2'b00, r_frame[1], 2'b00};
    assign paddr = base + 12'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= 11'd1024;
            r_uid1 <= 24'h04E3EF;
            r_uid2 <= 32'hA2EF2080;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MEM_SIZE: r_mem_size <= i_cfg_data[10:0];
                REG_UID1:     r_uid1 <= i_cfg_data[23:0];
                REG_UID2:     r_uid2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == (MEM_AW+1)'(MEM_BYTES - 1)) n_state = S_RX;
            S_RX:     if (s_axis_tvalid && (s_axis_tuser || s_axis_tlast)) n_state = S_DECODE;
            S_DECODE: begin
                n_state = S_RX;
                if (r_phase == PH_READY) begin
                    if ((r_frame[0] == CMD_SEL1 || r_frame[0] == CMD_SEL2)
                        && r_frame[1] == NVB_ANTI) n_state = S_SEND;
                    else if ((r_frame[0] == CMD_SEL1 || r_frame[0] == CMD_SEL2)
                        && r_frame[1] == NVB_SEL) n_state = S_CRC;
                end else if (r_phase == PH_ACTIVE) begin
                    if (r_frame[0] == CMD_READ) n_state = S_RDADDR;
                    else if (r_frame[0] == CMD_WRITE) n_state = S_WRCHK;
                end else if (r_fcnt == FCNT_W'(1) && (r_frame[0] == CMD_WUPA
                             || (r_frame[0] == CMD_REQA && !r_halted))) n_state = S_SEND;
            end
            S_RDADDR: n_state = S_RDDATA;
            S_RDDATA: n_state = (r_cnt == TX_AW'(READ_BYTES - 1)) ? S_CRC : S_RDADDR;
            S_CRC:    if (r_cnt == r_txn) n_state = S_SEND;
            S_WRCHK:  if (r_cnt == TX_AW'(6)) n_state =
                          (r_frame[6] == r_crc[7:0] && r_frame[7] == r_crc[15:8])
                          ? S_WRMEM : S_SEND;
            S_WRMEM:  if (r_cnt == TX_AW'(3)) n_state = S_SEND;
            S_SEND:   if (m_axis_tready && r_txi == r_txn - TX_AW'(1)) n_state = S_RX;
            default:  n_state = S_RX;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_halted = r_halted;
        if (r_state == S_DECODE) begin
            if (r_phase == PH_READY) begin
                if ((r_frame[0] == CMD_SEL1 || r_frame[0] == CMD_SEL2)
                    && (r_frame[1] == NVB_ANTI || r_frame[1] == NVB_SEL)) begin
                    if (r_frame[0] == CMD_SEL2 && r_frame[1] == NVB_SEL) n_phase = PH_ACTIVE;
                end else n_phase = PH_IDLE;
            end else if (r_phase == PH_ACTIVE) begin
                if (r_frame[0] == CMD_READ || r_frame[0] == CMD_WRITE) n_phase = PH_ACTIVE;
                else if (r_frame[0] == CMD_HALT && r_frame[2] == HALT_B2) begin
                    n_phase = PH_IDLE;
                    n_halted = 1'b1;
                end else if (r_fcnt != '0) n_phase = PH_IDLE;
            end else if (n_state == S_SEND) n_phase = PH_READY;
        end
    end

    assign s_axis_tready = (r_state == S_RX);
    assign m_axis_tvalid = (r_state == S_SEND);
    assign m_axis_tdata  = r_tx[r_txi];
    assign m_axis_tlast  = (r_txi == r_txn - TX_AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_IDLE;
            r_halted <= 1'b0;
            r_fcnt <= '0;
            r_clr <= '0;
            r_txi <= '0;
            r_txn <= '0;
            r_cnt <= '0;
            for (int i = 0; i < FRAME_BYTES; i++) r_frame[i] <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_halted <= n_halted;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_RX: if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        for (int i = 0; i < FRAME_BYTES; i++) r_frame[i] <= '0;
                        r_fcnt <= '0;
                    end else if (r_fcnt < FCNT_W'(FRAME_BYTES)) begin
                        r_frame[r_fcnt[FRAME_AW-1:0]] <= s_axis_tdata;
                        r_fcnt <= r_fcnt + 1'b1;
                    end
                end
                S_DECODE: begin
                    r_cnt <= '0;
                    r_txi <= '0;
                    r_crc <= CRC_INIT;
                    if (r_phase == PH_READY && r_frame[1] == NVB_ANTI) begin
                        r_txn <= TX_AW'(5);
                        if (r_frame[0] == CMD_SEL1) begin
                            r_tx[0] <= CT_BYTE; r_tx[1] <= r_uid1[23:16];
                            r_tx[2] <= r_uid1[15:8]; r_tx[3] <= r_uid1[7:0];
                            r_tx[4] <= CT_BYTE ^ r_uid1[23:16] ^ r_uid1[15:8] ^ r_uid1[7:0];
                        end else begin
                            r_tx[0] <= r_uid2[31:24]; r_tx[1] <= r_uid2[23:16];
                            r_tx[2] <= r_uid2[15:8]; r_tx[3] <= r_uid2[7:0];
                            r_tx[4] <= r_uid2[31:24] ^ r_uid2[23:16] ^ r_uid2[15:8]
                                       ^ r_uid2[7:0];
                        end
                    end else if (r_phase == PH_READY) begin
                        r_tx[0] <= (r_frame[0] == CMD_SEL1) ? SAK_CASC : 8'h00;
                        r_txn <= TX_AW'(1);
                    end else if (r_phase == PH_ACTIVE) begin
                        r_txn <= TX_AW'(1);
                    end else begin
                        r_tx[0] <= ATQA_LO; r_tx[1] <= 8'h00;
                        r_txn <= TX_AW'(2);
                    end
                end
                S_RDADDR: ;
                S_RDDATA: begin
                    r_tx[r_cnt] <= r_rd_ok ? r_rdata : 8'h00;
                    r_cnt <= r_cnt + 1'b1;
                    if (n_state == S_CRC) begin
                        r_cnt <= '0;
                        r_txn <= TX_AW'(READ_BYTES);
                    end
                end
                S_CRC: begin
                    if (r_cnt == r_txn) begin
                        r_tx[r_txn] <= r_crc[7:0];
                        r_tx[r_txn + 1'b1] <= r_crc[15:8];
                        r_txn <= r_txn + TX_AW'(2);
                    end else begin
                        r_crc <= crc_step(r_crc, r_tx[r_cnt]);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WRCHK: begin
                    if (r_cnt == TX_AW'(6)) begin
                        r_cnt <= '0;
                        r_tx[0] <= (n_state == S_WRMEM) ? RSP_ACK : RSP_NAK;
                    end else begin
                        r_crc <= crc_step(r_crc, r_frame[r_cnt[FRAME_AW-1:0]]);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WRMEM: r_cnt <= r_cnt + 1'b1;
                S_SEND: if (m_axis_tready) r_txi <= r_txi + 1'b1;
                default: ;
            endcase
            if (r_state == S_SEND && n_state == S_RX || r_state == S_DECODE && n_state == S_RX)
            begin
                for (int i = 0; i < FRAME_BYTES; i++) r_frame[i] <= '0;
                r_fcnt <= '0;
                r_txi <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR)
            mem[r_clr[MEM_AW-1:0]] <= 8'h00;
        else if (r_state == S_WRMEM && paddr < lim)
            mem[paddr[MEM_AW-1:0]] <= r_frame[FRAME_AW'(2) + FRAME_AW'(r_cnt[1:0])];
        r_rdata <= mem[paddr[MEM_AW-1:0]];
        r_rd_ok <= paddr < lim;
    end

    a_ready_only_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while replying");
    a_fcnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FCNT_W'(FRAME_BYTES)) else $error("frame count overflow");
    a_reply_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_txn != '0 && r_txi < r_txn)) else $error("bad reply index");
endmodule

>>> sim/tb_iso14443a_type2_tag_responder.sv
// Testbench for the Type 2 tag responder: drives reader frames and checks reply words
// against a behavioral model of phases, anticollision, READ/WRITE and memory.
// Depends on t2tag_pkg and iso14443a_type2_tag_responder.
module tb_iso14443a_type2_tag_responder;
    import t2tag_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    iso14443a_type2_tag_responder DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply;

    t_reply     reply_q[$];
    int         errors = 0;
    int         send_idle = 0;
    int         recv_idle = 0;

    logic [10:0] m_size;
    logic [23:0] m_uid1;
    logic [31:0] m_uid2;
    t_phase      m_phase;
    logic        m_halted;
    logic [7:0]  m_frame[FRAME_BYTES];
    int          m_count;
    logic [7:0]  m_mem[MEM_BYTES];

    function automatic logic [15:0] crc_of(input logic [7:0] b[], input int n);
        logic [15:0] crc;
        logic [7:0]  c;
        crc = 16'h6363;
        for (int i = 0; i < n; i++) begin
            c = b[i] ^ crc[7:0];
            c = c ^ (c << 4);
            crc = (crc >> 8) ^ (16'(c) << 8) ^ (16'(c) << 3) ^ (16'(c) >> 4);
        end
        return crc;
    endfunction

    task automatic push_reply(input logic [7:0] b[], input int n);
        for (int k = 0; k < n; k++) reply_q.push_back('{b[k], k == n - 1});
    endtask

    task automatic answer_frame();
        logic [7:0]  tx[];
        logic [15:0] crc;
        int          lim;
        int          pos;
        tx = new[READ_BYTES + 2];
        lim = (m_size < MEM_BYTES) ? m_size : MEM_BYTES;
        if (m_phase == PH_READY) begin
            if (m_frame[0] == CMD_SEL1 && m_frame[1] == NVB_ANTI) begin
                tx[0] = CT_BYTE; tx[1] = m_uid1[23:16]; tx[2] = m_uid1[15:8];
                tx[3] = m_uid1[7:0]; tx[4] = tx[0] ^ tx[1] ^ tx[2] ^ tx[3];
                push_reply(tx, 5);
            end else if (m_frame[0] == CMD_SEL2 && m_frame[1] == NVB_ANTI) begin
                tx[0] = m_uid2[31:24]; tx[1] = m_uid2[23:16]; tx[2] = m_uid2[15:8];
                tx[3] = m_uid2[7:0]; tx[4] = tx[0] ^ tx[1] ^ tx[2] ^ tx[3];
                push_reply(tx, 5);
            end else if ((m_frame[0] == CMD_SEL1 || m_frame[0] == CMD_SEL2)
                         && m_frame[1] == NVB_SEL) begin
                tx[0] = (m_frame[0] == CMD_SEL1) ? SAK_CASC : 8'h00;
                crc = crc_of(tx, 1);
                tx[1] = crc[7:0]; tx[2] = crc[15:8];
                if (m_frame[0] == CMD_SEL2) m_phase = PH_ACTIVE;
                push_reply(tx, 3);
            end else begin
                m_phase = PH_IDLE;
            end
        end else if (m_phase == PH_ACTIVE) begin
            pos = int'(m_frame[1]) * 4;
            if (m_frame[0] == CMD_READ) begin
                for (int i = 0; i < READ_BYTES; i++)
                    tx[i] = (pos + i < lim) ? m_mem[pos + i] : 8'h00;
                crc = crc_of(tx, READ_BYTES);
                tx[READ_BYTES] = crc[7:0]; tx[READ_BYTES + 1] = crc[15:8];
                push_reply(tx, READ_BYTES + 2);
            end else if (m_frame[0] == CMD_WRITE) begin
                crc = crc_of(m_frame, 6);
                if (m_frame[6] == crc[7:0] && m_frame[7] == crc[15:8]) begin
                    for (int i = 0; i < 4; i++)
                        if (pos + i < lim) m_mem[pos + i] = m_frame[2 + i];
                    tx[0] = RSP_ACK;
                end else begin
                    tx[0] = RSP_NAK;
                end
                push_reply(tx, 1);
            end else if (m_frame[0] == CMD_HALT && m_frame[2] == HALT_B2) begin
                m_phase = PH_IDLE;
                m_halted = 1'b1;
            end else if (m_count != 0) begin
                m_phase = PH_IDLE;
            end
        end else if (m_count == 1 && (m_frame[0] == CMD_WUPA
                     || (m_frame[0] == CMD_REQA && !m_halted))) begin
            tx[0] = ATQA_LO; tx[1] = 8'h00;
            m_phase = PH_READY;
            push_reply(tx, 2);
        end
        foreach (m_frame[i]) m_frame[i] = '0;
        m_count = 0;
    endtask

    task automatic predict_word(input logic mode, input logic [7:0] b, input logic last);
        if (mode) begin
            foreach (m_frame[i]) m_frame[i] = '0;
            m_count = 0;
            answer_frame();
        end else begin
            if (m_count < FRAME_BYTES) begin
                m_frame[m_count] = b;
                m_count++;
            end
            if (last) answer_frame();
        end
    endtask

    task automatic send_word(input logic mode, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_word(mode, b, last);
    endtask

    task automatic send_frame(input logic [7:0] b[]);
        foreach (b[i]) send_word(1'b0, b[i], i == b.size() - 1);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        while (n < 60) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        drain();
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MEM_SIZE: m_size = v[10:0];
            REG_UID1:     m_uid1 = v[23:0];
            default:      m_uid2 = v;
        endcase
    endtask

    task automatic wake_and_select(input logic wupa);
        send_frame('{wupa ? CMD_WUPA : CMD_REQA});
        send_frame('{CMD_SEL1, NVB_ANTI});
        send_frame('{CMD_SEL1, NVB_SEL, 8'h00, 8'h00});
        send_frame('{CMD_SEL2, NVB_ANTI});
        send_frame('{CMD_SEL2, NVB_SEL});
    endtask

    task automatic write_block(input logic [7:0] blk, input logic good);
        logic [7:0]  f[];
        logic [15:0] crc;
        f = new[8];
        f[0] = CMD_WRITE; f[1] = blk;
        for (int i = 2; i < 6; i++) f[i] = 8'($urandom);
        crc = crc_of(f, 6);
        f[6] = crc[7:0]; f[7] = good ? crc[15:8] : ~crc[15:8];
        send_frame(f);
    endtask

    task automatic test_directed();
        wake_and_select(1'b0);
        write_block(8'd0, 1'b1);
        write_block(8'd255, 1'b1);
        write_block(8'd1, 1'b0);
        send_frame('{CMD_READ, 8'd0});
        send_frame('{CMD_READ, 8'd255});
        send_word(1'b1, 8'hFF, 1'b1);
        send_frame('{CMD_HALT, 8'h00, HALT_B2, 8'h00});
        send_frame('{CMD_REQA});
        send_frame('{CMD_WUPA, 8'h00});
        send_frame('{CMD_WUPA});
        send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_word(1'b0, 8'h93, 1'b0);
        send_word(1'b1, 8'h00, 1'b0);
    endtask

    task automatic test_random(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(9))
                0, 1: begin wake_and_select(1'($urandom_range(1))); sent += 11; end
                2, 3: begin write_block(8'($urandom_range(300) % 256), $urandom_range(3) != 0);
                        sent += 8; end
                4, 5: begin send_frame('{CMD_READ, 8'($urandom_range(300) % 256)}); sent += 2; end
                6: begin send_frame('{CMD_HALT, 8'($urandom), ($urandom_range(1) ? HALT_B2
                        : 8'($urandom))}); sent += 3; end
                7: begin send_word(1'b1, 8'($urandom), 1'($urandom)); sent++; end
                default: begin
                    send_word(1'b0, 8'($urandom), 1'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    task automatic test_configs();
        write_reg(REG_MEM_SIZE, 32'd0);
        write_reg(REG_UID1, 32'hFFFFFF);
        write_reg(REG_UID2, 32'hFFFFFFFF);
        test_random(80);
        write_reg(REG_MEM_SIZE, 32'd37);
        write_reg(REG_UID1, 32'h000000);
        write_reg(REG_UID2, 32'h00000000);
        test_random(80);
        write_reg(REG_MEM_SIZE, 32'hFFFFFFFF);
        write_reg(REG_UID1, $urandom);
        write_reg(REG_UID2, $urandom);
        test_random(80);
        write_reg(REG_MEM_SIZE, 32'd1024);
    endtask

    always @(posedge i_clk) begin
        t_reply exp_w;
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
        if (m_axis_tvalid && m_axis_tready) begin
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                         m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                exp_w = reply_q.pop_front();
                if (exp_w.data !== m_axis_tdata || exp_w.last !== m_axis_tlast) begin
                    $display("%0t: mismatch, expected %h/%b, actual %h/%b", $time,
                             exp_w.data, exp_w.last, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("tb_iso14443a_type2_tag_responder: done, errors");
        $finish;
    end

    initial begin
        m_size = 11'd1024; m_uid1 = 24'h04E3EF; m_uid2 = 32'hA2EF2080;
        m_phase = PH_IDLE; m_halted = 1'b0; m_count = 0;
        foreach (m_frame[i]) m_frame[i] = '0;
        foreach (m_mem[i]) m_mem[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 15; recv_idle = 49;
        test_directed();
        test_random(100);
        send_idle = 49; recv_idle = 15;
        test_configs();
        send_idle = 0; recv_idle = 0;
        test_random(100);
        drain();
        if (errors == 0 && reply_q.size() == 0) begin
            $display("tb_iso14443a_type2_tag_responder: done, clean");
        end else begin
            $display("tb_iso14443a_type2_tag_responder: done, errors");
        end
        $finish;
    end
endmodule
